// File: sv/mco_pkg.sv
`default_nettype none

package mco_pkg;

   // Fixed sizes of the stores
   localparam int unsigned MAX_POINTS   = 32;
   localparam int unsigned MAX_ELEMENTS = 64;
   localparam int unsigned IMG_DEPTH    = MAX_ELEMENTS * MAX_POINTS;
   localparam int unsigned LIST_DEPTH   = (MAX_POINTS + 1) * MAX_ELEMENTS;
   localparam int unsigned IMG_ADDR_W   = $clog2(IMG_DEPTH);
   localparam int unsigned LIST_ADDR_W  = $clog2(LIST_DEPTH);

   localparam logic [5:0] POINT_LIMIT = 6'd32;
   localparam logic [6:0] ELT_LIMIT   = 7'd64;

   typedef enum logic [1:0] {
      REQ_ADJ     = 2'd0,
      REQ_IMG     = 2'd1,
      REQ_NEXT    = 2'd2,
      REQ_RESTART = 2'd3
   } req_code_type;

   typedef enum logic {
      CSR_NUM_POINTS   = 1'b0,
      CSR_NUM_ELEMENTS = 1'b1
   } csr_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NODE,
      ST_RED,
      ST_UP,
      ST_CM_INIT,
      ST_CM_FETCH,
      ST_CM_ELT,
      ST_CM_IMG,
      ST_CM_EVAL,
      ST_LEAF,
      ST_MAX_INIT,
      ST_MAX,
      ST_EMIT_LEAF,
      ST_EMIT_DONE
   } state_type;

   typedef struct packed {
      logic req_take;
      logic start;
      logic set_done;
      logic try_blue;
      logic try_red;
      logic try_up;
      logic adj_up;
      logic lvl_dec;
      logic cm_init;
      logic cm_take;
      logic img_step;
      logic cm_eval;
      logic cm_commit;
      logic max_init;
      logic max_step;
      logic load_leaf;
      logic load_done;
   } cmd_type;

   typedef struct packed {
      logic started;
      logic done;
      logic lvl_ge_n;
      logic lvl_eq_n;
      logic lvl_zero;
      logic up_ok;
      logic red_ok;
      logic cm_end;
      logic img_done;
      logic prune;
      logic max_end;
      logic maximal;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

// File: sv/maximal_clique_orbit_enumerator.sv
// Writes (adjacency bit, permutation image) and restart: taken while idle, no result item.
// Next: data dependent; each tree node filters its admissible list with one image RAM
//   read per point for each permutation; a full-depth leaf adds a maximality sweep.
// One item at a time; a finished result may wait in the output register meanwhile.
// Reset (synchronous): search not started, registers num_points = num_elements = 1;
//   adjacency and image stores stay undefined until written.
`default_nettype none

module maximal_clique_orbit_enumerator (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [5:0]  req_row_index,
   input  wire logic [4:0]  req_col_index,
   input  wire logic [4:0]  req_write_value,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_clique_mask,
   output logic [5:0]       rsp_clique_size,
   output logic [6:0]       rsp_admissible_count,
   output logic             rsp_exhausted,
   // register writes
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_wr_data
);

   // The controller walks the depth-first tree: blue first, then red, then
   // backtracking; the datapath holds the colouring of the current path in one
   // word (bits below the level are live), the per-level admissible lists in
   // a RAM and the per-level counts in flops.
   mco_pkg::cmd_type    cmd;
   mco_pkg::status_type stat;

   mco_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: filter unit (image scan, first-difference test), adjacency
   // flops, maximality sweep and the output register.
   mco_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_type             (req_type),
      .req_row_index        (req_row_index),
      .req_col_index        (req_col_index),
      .req_write_value      (req_write_value),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_clique_mask      (rsp_clique_mask),
      .rsp_clique_size      (rsp_clique_size),
      .rsp_admissible_count (rsp_admissible_count),
      .rsp_exhausted        (rsp_exhausted)
   );

endmodule

`default_nettype wire

// File: sv/mco_ram.sv
`default_nettype none

module mco_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/mco_ctrl.sv
`default_nettype none

module mco_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_type,
   output logic                      req_stall,
   input  wire mco_pkg::status_type  stat,
   output mco_pkg::cmd_type          cmd
);

   typedef enum logic [1:0] {
      MODE_BLUE,
      MODE_RED,
      MODE_UP
   } mode_type;

   mco_pkg::state_type state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic               is_next;

   assign is_next = (req_type == mco_pkg::REQ_NEXT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mco_pkg::ST_IDLE;
         mode_ff  <= MODE_BLUE;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      unique case (state_ff)
         mco_pkg::ST_IDLE: begin
            if (req_valid && is_next) begin
               if (stat.done) begin
                  state_in = mco_pkg::ST_EMIT_DONE;
               end else if (!stat.started) begin
                  state_in = mco_pkg::ST_LEAF;
               end else begin
                  state_in = mco_pkg::ST_NODE;
               end
            end
         end
         mco_pkg::ST_NODE: begin
            if (stat.lvl_ge_n) begin
               state_in = mco_pkg::ST_UP;
            end else begin
               state_in = mco_pkg::ST_CM_INIT;
               mode_in  = MODE_BLUE;
            end
         end
         mco_pkg::ST_RED: begin
            if (stat.red_ok) begin
               state_in = mco_pkg::ST_CM_INIT;
               mode_in  = MODE_RED;
            end else begin
               state_in = mco_pkg::ST_UP;
            end
         end
         mco_pkg::ST_UP: begin
            if (stat.up_ok) begin
               state_in = mco_pkg::ST_CM_INIT;
               mode_in  = MODE_UP;
            end else if (stat.lvl_zero) begin
               state_in = mco_pkg::ST_EMIT_DONE;
            end
         end
         mco_pkg::ST_CM_INIT:  state_in = mco_pkg::ST_CM_FETCH;
         mco_pkg::ST_CM_FETCH: begin
            state_in = stat.cm_end ? mco_pkg::ST_LEAF : mco_pkg::ST_CM_ELT;
         end
         mco_pkg::ST_CM_ELT:   state_in = mco_pkg::ST_CM_IMG;
         mco_pkg::ST_CM_IMG: begin
            if (stat.img_done) begin
               state_in = mco_pkg::ST_CM_EVAL;
            end
         end
         mco_pkg::ST_CM_EVAL: begin
            if (stat.prune) begin
               state_in = (mode_ff == MODE_BLUE) ? mco_pkg::ST_RED : mco_pkg::ST_UP;
            end else begin
               state_in = mco_pkg::ST_CM_FETCH;
            end
         end
         mco_pkg::ST_LEAF: begin
            state_in = stat.lvl_eq_n ? mco_pkg::ST_MAX_INIT : mco_pkg::ST_NODE;
         end
         mco_pkg::ST_MAX_INIT: state_in = mco_pkg::ST_MAX;
         mco_pkg::ST_MAX: begin
            if (stat.max_end) begin
               state_in = stat.maximal ? mco_pkg::ST_EMIT_LEAF : mco_pkg::ST_NODE;
            end
         end
         mco_pkg::ST_EMIT_LEAF, mco_pkg::ST_EMIT_DONE: begin
            if (stat.rsp_free) begin
               state_in = mco_pkg::ST_IDLE;
            end
         end
         default: state_in = mco_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != mco_pkg::ST_IDLE);
      unique case (state_ff)
         mco_pkg::ST_IDLE: begin
            cmd.req_take = req_valid;
            cmd.start    = req_valid && is_next && !stat.done && !stat.started;
         end
         mco_pkg::ST_NODE:     cmd.try_blue = !stat.lvl_ge_n;
         mco_pkg::ST_RED:      cmd.try_red  = stat.red_ok;
         mco_pkg::ST_UP: begin
            cmd.adj_up   = 1'b1;
            cmd.try_up   = stat.up_ok;
            cmd.set_done = !stat.up_ok && stat.lvl_zero;
            cmd.lvl_dec  = !stat.up_ok && !stat.lvl_zero;
         end
         mco_pkg::ST_CM_INIT:  cmd.cm_init   = 1'b1;
         mco_pkg::ST_CM_FETCH: cmd.cm_commit = stat.cm_end;
         mco_pkg::ST_CM_ELT:   cmd.cm_take   = 1'b1;
         mco_pkg::ST_CM_IMG:   cmd.img_step  = 1'b1;
         mco_pkg::ST_CM_EVAL: begin
            cmd.cm_eval = 1'b1;
            cmd.lvl_dec = stat.prune && (mode_ff == MODE_UP);
         end
         mco_pkg::ST_LEAF:      cmd = '0;
         mco_pkg::ST_MAX_INIT:  cmd.max_init  = 1'b1;
         mco_pkg::ST_MAX:       cmd.max_step  = 1'b1;
         mco_pkg::ST_EMIT_LEAF: cmd.load_leaf = stat.rsp_free;
         mco_pkg::ST_EMIT_DONE: cmd.load_done = stat.rsp_free;
         default:               cmd = '0;
      endcase
   end

   // a leaf is only reported at full depth and after the maximality sweep passed
   a_leaf_is_maximal: assert property (@(posedge clock) disable iff (reset)
      cmd.load_leaf |-> (stat.lvl_eq_n && stat.maximal))
      else $error("leaf reported that is not a maximal full-depth clique");

endmodule

`default_nettype wire

// File: sv/mco_dp.sv
`default_nettype none

module mco_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mco_pkg::cmd_type    cmd,
   output mco_pkg::status_type      stat,
   input  wire logic [1:0]          req_type,
   input  wire logic [5:0]          req_row_index,
   input  wire logic [4:0]          req_col_index,
   input  wire logic [4:0]          req_write_value,
   input  wire logic                csr_wr_en,
   input  wire logic                csr_index,
   input  wire logic [6:0]          csr_wr_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [31:0]              rsp_clique_mask,
   output logic [5:0]               rsp_clique_size,
   output logic [6:0]               rsp_admissible_count,
   output logic                     rsp_exhausted
);

   function automatic logic [31:0] below(input logic [5:0] n);
      below = n[5] ? '1 : ((32'd1 << n[4:0]) - 32'd1);
   endfunction

   // configuration and search control
   logic [5:0]  num_points_ff;
   logic [6:0]  num_elements_ff;
   logic [5:0]  npts_ff;
   logic [6:0]  nelt_ff;
   logic        started_ff, done_ff;
   logic [5:0]  lvl_ff;
   logic [31:0] col_ff;

   // admissible-list filter
   logic [5:0]  cm_lvl_ff;
   logic [6:0]  j_ff, kept_ff, cnt_ff, last_kept_ff;
   logic [5:0]  elt_ff;
   logic [5:0]  i_ff;
   logic        pend_ff;
   logic [4:0]  pend_i_ff;
   logic [31:0] def_ff, val_ff;
   logic [6:0]  count_ff [mco_pkg::MAX_POINTS];

   // maximality sweep
   logic [5:0]  f_ff;
   logic [31:0] common_ff;
   logic [5:0]  size_ff;

   logic [31:0] adj_ff [mco_pkg::MAX_POINTS];

   logic        rsp_valid_ff;
   logic [31:0] rsp_mask_ff;
   logic [5:0]  rsp_size_ff;
   logic [6:0]  rsp_count_ff;
   logic        rsp_exh_ff;

   logic [5:0]  lpts, lvl_m1, src, cm_m2;
   logic [6:0]  lelt, cnt_sel;
   logic [4:0]  adj_addr;
   logic [31:0] adj_row, clique, x, lsb;
   logic        adm_ok, src_root, hit, prune, drop, keep, img_issue;
   logic        img_we, list_we;
   logic [4:0]  img_rd;
   logic [5:0]  list_rd;

   assign lpts   = (num_points_ff > mco_pkg::POINT_LIMIT) ? mco_pkg::POINT_LIMIT : num_points_ff;
   assign lelt   = (num_elements_ff > mco_pkg::ELT_LIMIT) ? mco_pkg::ELT_LIMIT : num_elements_ff;
   assign lvl_m1 = lvl_ff - 6'd1;
   assign src    = cm_lvl_ff - 6'd1;
   assign cm_m2  = cm_lvl_ff - 6'd2;
   assign src_root = (cm_lvl_ff == 6'd1);
   assign cnt_sel  = src_root ? nelt_ff : count_ff[cm_m2[4:0]];

   assign adj_addr = cmd.max_step ? f_ff[4:0] : (cmd.adj_up ? lvl_m1[4:0] : lvl_ff[4:0]);
   assign adj_row  = adj_ff[adj_addr];
   assign clique   = col_ff & below(lvl_ff);
   assign adm_ok   = ((adj_row & clique) == clique);

   // first place where the permuted colouring is unknown or differs
   assign x     = below(cm_lvl_ff) & (~def_ff | (val_ff ^ col_ff));
   assign lsb   = x & (~x + 32'd1);
   assign hit   = (lsb != '0);
   assign prune = hit && ((lsb & def_ff) != '0) && ((lsb & col_ff) == '0);
   assign drop  = hit && ((lsb & def_ff) != '0) && ((lsb & col_ff) != '0);
   assign keep  = !prune && !drop;

   assign img_issue = cmd.img_step && (i_ff != cm_lvl_ff);
   assign img_we    = cmd.req_take && (req_type == mco_pkg::REQ_IMG);
   assign list_we   = cmd.cm_eval && keep;

   always_comb begin
      stat          = '0;
      stat.started  = started_ff;
      stat.done     = done_ff;
      stat.lvl_ge_n = (lvl_ff >= npts_ff);
      stat.lvl_eq_n = (lvl_ff == npts_ff);
      stat.lvl_zero = (lvl_ff == 6'd0);
      stat.up_ok    = (lvl_ff != 6'd0) && !col_ff[lvl_m1[4:0]] && adm_ok;
      stat.red_ok   = adm_ok;
      stat.cm_end   = (j_ff == cnt_ff);
      stat.img_done = (i_ff == cm_lvl_ff) && !pend_ff;
      stat.prune    = prune;
      stat.max_end  = (f_ff == npts_ff);
      stat.maximal  = ((~col_ff & common_ff & below(npts_ff)) == '0);
      stat.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   mco_ram #(
      .WIDTH (5),
      .DEPTH (mco_pkg::IMG_DEPTH)
   ) u_img_ram (
      .clock   (clock),
      .wr_en   (img_we),
      .wr_addr ({req_row_index, req_col_index}),
      .wr_data (req_write_value),
      .rd_addr ({elt_ff, i_ff[4:0]}),
      .rd_data (img_rd)
   );

   mco_ram #(
      .WIDTH (6),
      .DEPTH (mco_pkg::LIST_DEPTH)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (list_we),
      .wr_addr ({cm_lvl_ff, kept_ff[5:0]}),
      .wr_data (elt_ff),
      .rd_addr ({src, j_ff[5:0]}),
      .rd_data (list_rd)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff   <= 6'd1;
         num_elements_ff <= 7'd1;
         started_ff      <= 1'b0;
         done_ff         <= 1'b0;
         lvl_ff          <= 6'd0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               mco_pkg::CSR_NUM_POINTS:   num_points_ff   <= csr_wr_data[5:0];
               mco_pkg::CSR_NUM_ELEMENTS: num_elements_ff <= csr_wr_data;
               default:                   num_points_ff   <= num_points_ff;
            endcase
         end
         if (cmd.req_take && (req_type == mco_pkg::REQ_RESTART)) begin
            started_ff <= 1'b0;
            done_ff    <= 1'b0;
            lvl_ff     <= 6'd0;
         end
         if (cmd.start) begin
            started_ff <= 1'b1;
            done_ff    <= 1'b0;
            lvl_ff     <= 6'd0;
         end
         if (cmd.set_done) begin
            done_ff <= 1'b1;
         end
         if (cmd.lvl_dec) begin
            lvl_ff <= lvl_m1;
         end
         if (cmd.cm_commit) begin
            lvl_ff <= cm_lvl_ff;
         end
         if (cmd.cm_take) begin
            pend_ff <= 1'b0;
         end else if (cmd.img_step) begin
            pend_ff <= img_issue;
         end
         if (cmd.load_leaf || cmd.load_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_take && (req_type == mco_pkg::REQ_ADJ) && !req_row_index[5]) begin
         adj_ff[req_row_index[4:0]][req_col_index] <= (req_write_value != 5'd0);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         npts_ff      <= lpts;
         nelt_ff      <= lelt;
         col_ff       <= '0;
         last_kept_ff <= lelt;
      end
      if (cmd.try_blue) begin
         col_ff[lvl_ff[4:0]] <= 1'b0;
         cm_lvl_ff           <= lvl_ff + 6'd1;
      end
      if (cmd.try_red) begin
         col_ff[lvl_ff[4:0]] <= 1'b1;
         cm_lvl_ff           <= lvl_ff + 6'd1;
      end
      if (cmd.try_up) begin
         col_ff[lvl_m1[4:0]] <= 1'b1;
         cm_lvl_ff           <= lvl_ff;
      end
      if (cmd.cm_init) begin
         j_ff    <= 7'd0;
         kept_ff <= 7'd0;
         cnt_ff  <= cnt_sel;
      end
      if (cmd.cm_take) begin
         elt_ff <= src_root ? j_ff[5:0] : list_rd;
         i_ff   <= 6'd0;
         def_ff <= '0;
      end
      if (img_issue) begin
         i_ff      <= i_ff + 6'd1;
         pend_i_ff <= i_ff[4:0];
      end
      // later points overwrite earlier ones that share an image
      if (cmd.img_step && pend_ff && ({1'b0, img_rd} < cm_lvl_ff)) begin
         def_ff[img_rd] <= 1'b1;
         val_ff[img_rd] <= col_ff[pend_i_ff];
      end
      if (cmd.cm_eval) begin
         j_ff <= j_ff + 7'd1;
         if (keep) begin
            kept_ff <= kept_ff + 7'd1;
         end
      end
      if (cmd.cm_commit) begin
         count_ff[src[4:0]] <= kept_ff;
         last_kept_ff       <= kept_ff;
      end
      if (cmd.max_init) begin
         f_ff      <= 6'd0;
         common_ff <= '1;
         size_ff   <= 6'd0;
      end
      if (cmd.max_step && (f_ff != npts_ff)) begin
         f_ff <= f_ff + 6'd1;
         if (clique[f_ff[4:0]]) begin
            common_ff <= common_ff & adj_row;
            size_ff   <= size_ff + 6'd1;
         end
      end
      if (cmd.load_leaf) begin
         rsp_mask_ff  <= clique;
         rsp_size_ff  <= size_ff;
         rsp_count_ff <= last_kept_ff;
         rsp_exh_ff   <= 1'b0;
      end
      if (cmd.load_done) begin
         rsp_mask_ff  <= '0;
         rsp_size_ff  <= 6'd0;
         rsp_count_ff <= 7'd0;
         rsp_exh_ff   <= 1'b1;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_clique_mask      = rsp_mask_ff;
   assign rsp_clique_size      = rsp_size_ff;
   assign rsp_admissible_count = rsp_count_ff;
   assign rsp_exhausted        = rsp_exh_ff;

   a_kept_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.cm_eval |-> (kept_ff <= j_ff))
      else $error("more permutations kept than examined");

   a_level_bounded: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> (lvl_ff <= npts_ff))
      else $error("search level beyond vertex count");

   a_exhausted_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_exh_ff) |-> ((rsp_mask_ff == '0) && (rsp_count_ff == 7'd0)))
      else $error("exhausted item carries a clique");

endmodule

`default_nettype wire

// File: test/maximal_clique_orbit_enumerator_test.sv
`default_nettype none

module maximal_clique_orbit_enumerator_test;

   localparam int unsigned CYCLE_LIMIT = 10_000_000;
   // vertex and group range of the random phases; every entry a search there
   // can read is loaded first
   localparam int unsigned SMALL_N = 7;
   localparam int unsigned SMALL_E = 6;

   // one result item as the block returns it
   typedef struct packed {
      logic [31:0] mask;
      logic [5:0]  size;
      logic [6:0]  count;
      logic        exhausted;
   } clique_res_type;

   // one row of the directed table: either a register write or a request item
   typedef struct {
      bit                    is_csr;
      mco_pkg::csr_code_type csr_reg;
      int unsigned           csr_val;
      mco_pkg::req_code_type kind;
      int unsigned           row;
      int unsigned           col;
      int unsigned           val;
      bit                    typed;       // expectation written out in the row
      clique_res_type        res;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = mco_pkg::REQ_ADJ;
   logic [5:0]  req_row_index = '0;
   logic [4:0]  req_col_index = '0;
   logic [4:0]  req_write_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [31:0] rsp_clique_mask;
   logic [5:0]  rsp_clique_size;
   logic [6:0]  rsp_admissible_count;
   logic        rsp_exhausted;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = mco_pkg::CSR_NUM_POINTS;
   logic [6:0]  csr_wr_data = '0;

   maximal_clique_orbit_enumerator dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_row_index        (req_row_index),
      .req_col_index        (req_col_index),
      .req_write_value      (req_write_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_clique_mask      (rsp_clique_mask),
      .rsp_clique_size      (rsp_clique_size),
      .rsp_admissible_count (rsp_admissible_count),
      .rsp_exhausted        (rsp_exhausted),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow of the enumerator: stores, search stack and latched sizes
   // ------------------------------------------------------------------
   logic [31:0] adj_rows [mco_pkg::MAX_POINTS];
   logic [4:0]  perm_img [mco_pkg::MAX_ELEMENTS][mco_pkg::MAX_POINTS];
   logic [31:0] lvl_colour [mco_pkg::MAX_POINTS + 1];
   logic [31:0] lvl_clique [mco_pkg::MAX_POINTS + 1];
   int unsigned lvl_list [mco_pkg::MAX_POINTS + 1][mco_pkg::MAX_ELEMENTS];
   int unsigned lvl_count [mco_pkg::MAX_POINTS + 1];
   int unsigned cur_lvl;
   bit          tree_done;
   bit          tree_started;
   int unsigned live_n, live_e;
   int unsigned reg_points = 1, reg_elements = 1;

   clique_res_type clique_expect_q [$];
   int unsigned mismatches = 0;
   int unsigned cycles = 0;

   // 0 cannot help, 1 may help later, 2 proves the colouring non-minimal
   function automatic int unsigned perm_verdict(int unsigned elt, int unsigned len,
                                                logic [31:0] colours);
      int unsigned scratch [mco_pkg::MAX_POINTS];
      int unsigned img;
      for (int unsigned i = 0; i < len; i++) scratch[i] = 2;
      for (int unsigned i = 0; i < len; i++) begin
         img = perm_img[elt][i];
         if (img < len) scratch[img] = colours[i];
      end
      for (int unsigned i = 0; i < len; i++) begin
         if (scratch[i] == 2) return 1;
         if (colours[i] == 1'b1 && scratch[i] == 0) return 0;
         if (colours[i] == 1'b0 && scratch[i] == 1) return 2;
      end
      return 1;
   endfunction

   // filter the parent's admissible list into level lvl; 0 when pruned
   function automatic bit filter_level(int unsigned lvl);
      int unsigned src, kept, cnt, elt, st;
      src = lvl - 1;
      kept = 0;
      cnt = lvl_count[src];
      if (cnt > mco_pkg::MAX_ELEMENTS) cnt = mco_pkg::MAX_ELEMENTS;
      for (int unsigned j = 0; j < cnt; j++) begin
         elt = lvl_list[src][j];
         if (elt < mco_pkg::MAX_ELEMENTS) begin
            st = perm_verdict(elt, lvl, lvl_colour[lvl]);
            if (st == 2) return 1'b0;
            if (st == 1) begin
               lvl_list[lvl][kept] = elt;
               kept++;
            end
         end
      end
      lvl_count[lvl] = kept;
      return 1'b1;
   endfunction

   function automatic bit can_join(logic [31:0] clq, int unsigned v);
      if (v >= mco_pkg::MAX_POINTS) return 1'b0;
      return (adj_rows[v] & clq) == clq;
   endfunction

   function automatic bit leaf_is_maximal();
      logic [31:0] clq, col;
      bit ok;
      clq = lvl_clique[live_n];
      col = lvl_colour[live_n];
      for (int unsigned v = 0; v < live_n; v++) begin
         if (!col[v]) begin
            ok = 1'b1;
            for (int unsigned f = 0; f < live_n && ok; f++)
               if (clq[f] && !adj_rows[f][v]) ok = 1'b0;
            if (ok) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic bit climb();
      int unsigned l;
      forever begin
         l = cur_lvl;
         if (l > 0) begin
            if (!lvl_colour[l][l-1] && can_join(lvl_clique[l], l - 1)) begin
               lvl_colour[l][l-1] = 1'b1;
               if (filter_level(l)) begin
                  lvl_clique[l][l-1] = 1'b1;
                  return 1'b1;
               end
            end
         end
         if (l == 0) return 1'b0;
         cur_lvl = l - 1;
      end
   endfunction

   function automatic bit step_tree();
      int unsigned l;
      l = cur_lvl;
      if (l >= live_n) return climb();
      lvl_clique[l+1] = lvl_clique[l];
      lvl_colour[l+1] = lvl_colour[l] & ((32'd1 << l) - 32'd1);
      // blue first
      lvl_colour[l+1][l] = 1'b0;
      if (filter_level(l + 1)) begin
         cur_lvl = l + 1;
         return 1'b1;
      end
      if (can_join(lvl_clique[l], l)) begin
         lvl_colour[l+1][l] = 1'b1;
         if (filter_level(l + 1)) begin
            cur_lvl = l + 1;
            lvl_clique[l+1][l] = 1'b1;
            return 1'b1;
         end
      end
      return climb();
   endfunction

   function automatic void begin_tree();
      live_n = (reg_points > mco_pkg::MAX_POINTS) ? mco_pkg::MAX_POINTS : reg_points;
      live_e = (reg_elements > mco_pkg::MAX_ELEMENTS) ? mco_pkg::MAX_ELEMENTS : reg_elements;
      for (int unsigned l = 0; l <= mco_pkg::MAX_POINTS; l++) begin
         lvl_colour[l] = '0;
         lvl_clique[l] = '0;
         lvl_count[l] = live_e;
         for (int unsigned j = 0; j < mco_pkg::MAX_ELEMENTS; j++) lvl_list[l][j] = j;
      end
      cur_lvl = 0;
      tree_done = 1'b0;
      tree_started = 1'b1;
   endfunction

   function automatic clique_res_type leaf_result();
      clique_res_type r;
      r.mask = lvl_clique[live_n];
      r.size = 6'($countones(r.mask));
      r.count = 7'(lvl_count[live_n]);
      r.exhausted = 1'b0;
      return r;
   endfunction

   // apply one accepted item; returns 1 with the clique it yields, if any
   function automatic bit predict_clique(mco_pkg::req_code_type kind, int unsigned row,
                                         int unsigned col, int unsigned val,
                                         output clique_res_type r);
      r = '0;
      unique case (kind)
         mco_pkg::REQ_ADJ: begin
            if (row < mco_pkg::MAX_POINTS) adj_rows[row][col] = (val != 0);
            return 1'b0;
         end
         mco_pkg::REQ_IMG: begin
            if (row < mco_pkg::MAX_ELEMENTS) perm_img[row][col] = 5'(val);
            return 1'b0;
         end
         mco_pkg::REQ_RESTART: begin
            tree_started = 1'b0;
            tree_done = 1'b0;
            cur_lvl = 0;
            return 1'b0;
         end
         default: begin
            if (!tree_done) begin
               if (!tree_started) begin
                  begin_tree();
                  if (cur_lvl == live_n && leaf_is_maximal()) begin
                     r = leaf_result();
                     return 1'b1;
                  end
               end
               while (step_tree())
                  if (cur_lvl == live_n && leaf_is_maximal()) begin
                     r = leaf_result();
                     return 1'b1;
                  end
               tree_done = 1'b1;
            end
            r.exhausted = 1'b1;
            return 1'b1;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Drivers: inputs move at the falling edge, handshakes seen at the rising
   // ------------------------------------------------------------------
   task automatic send_item(mco_pkg::req_code_type kind, int unsigned row, int unsigned col,
                            int unsigned val, bit typed = 1'b0,
                            clique_res_type typed_res = '0);
      int unsigned gap;
      clique_res_type r;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type = kind;
      req_row_index = 6'(row);
      req_col_index = 5'(col);
      req_write_value = 5'(val);
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      if (predict_clique(kind, row, col, val, r))
         clique_expect_q.insert(clique_expect_q.size(), typed ? typed_res : r);
      @(negedge clock);
   endtask

   // register write, only once the block has gone quiet
   task automatic write_reg(mco_pkg::csr_code_type idx, int unsigned value);
      req_valid = 1'b0;
      wait (clique_expect_q.size() == 0);
      repeat (4) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = 7'(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx == mco_pkg::CSR_NUM_POINTS) reg_points = value & 6'h3f;
      else reg_elements = value & 7'h7f;
   endtask

   // result side stall: a fresh wait per item
   initial begin
      int unsigned hold;
      @(negedge clock);
      forever begin
         hold = $urandom_range(0, 3);
         rsp_stall = (hold != 0);
         repeat (hold) @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // checker
   always @(posedge clock) begin
      clique_res_type got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_clique_mask, rsp_clique_size, rsp_admissible_count, rsp_exhausted};
         if (clique_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: mask %h size %0d count %0d exh %0d",
                        got.mask, got.size, got.count, got.exhausted);
         end else begin
            want = clique_expect_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp mask %h size %0d count %0d exh %0d, got %h %0d %0d %0d",
                           want.mask, want.size, want.count, want.exhausted,
                           got.mask, got.size, got.count, got.exhausted);
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   localparam clique_res_type EMPTY_LEAF = '{mask: '0, size: '0, count: '0, exhausted: 1'b0};
   localparam clique_res_type TREE_DONE  = '{mask: '0, size: '0, count: '0, exhausted: 1'b1};

   dir_row_type dir_tab [20];

   function automatic dir_row_type csr_row(mco_pkg::csr_code_type idx, int unsigned value);
      dir_row_type d;
      d.is_csr = 1'b1;
      d.csr_reg = idx;
      d.csr_val = value;
      d.kind = mco_pkg::REQ_ADJ;
      d.row = 0;
      d.col = 0;
      d.val = 0;
      d.typed = 1'b0;
      d.res = '0;
      return d;
   endfunction

   function automatic dir_row_type req_row(mco_pkg::req_code_type kind, int unsigned row,
                                           int unsigned col, int unsigned val, bit typed,
                                           clique_res_type res);
      dir_row_type d;
      d.is_csr = 1'b0;
      d.csr_reg = mco_pkg::CSR_NUM_POINTS;
      d.csr_val = 0;
      d.kind = kind;
      d.row = row;
      d.col = col;
      d.val = val;
      d.typed = typed;
      d.res = res;
      return d;
   endfunction

   initial begin
      int unsigned n, e, pick;
      // no vertices and no permutations: one empty leaf, then the tree is spent
      dir_tab[0]  = csr_row(mco_pkg::CSR_NUM_POINTS, 0);
      dir_tab[1]  = csr_row(mco_pkg::CSR_NUM_ELEMENTS, 0);
      dir_tab[2]  = req_row(mco_pkg::REQ_NEXT, 0, 0, 0, 1'b1, EMPTY_LEAF);
      dir_tab[3]  = req_row(mco_pkg::REQ_NEXT, 63, 31, 31, 1'b1, TREE_DONE);
      dir_tab[4]  = req_row(mco_pkg::REQ_NEXT, 0, 0, 0, 1'b1, TREE_DONE);
      dir_tab[5]  = req_row(mco_pkg::REQ_RESTART, 0, 0, 0, 1'b0, '0);
      // adjacency row beyond the vertex range is dropped
      dir_tab[6]  = req_row(mco_pkg::REQ_ADJ, 63, 31, 31, 1'b0, '0);
      // empty graph on the small vertex range: single-vertex cliques only
      dir_tab[7]  = csr_row(mco_pkg::CSR_NUM_POINTS, SMALL_N);
      dir_tab[8]  = csr_row(mco_pkg::CSR_NUM_ELEMENTS, 1);
      dir_tab[9]  = req_row(mco_pkg::REQ_NEXT, 0, 0, 0, 1'b0, '0);
      dir_tab[10] = req_row(mco_pkg::REQ_NEXT, 0, 0, 0, 1'b0, '0);
      dir_tab[11] = req_row(mco_pkg::REQ_RESTART, 0, 0, 0, 1'b0, '0);
      // oversize element count clamps to the full group
      dir_tab[12] = csr_row(mco_pkg::CSR_NUM_POINTS, 1);
      dir_tab[13] = csr_row(mco_pkg::CSR_NUM_ELEMENTS, 127);
      dir_tab[14] = req_row(mco_pkg::REQ_ADJ, 0, 1, 1, 1'b0, '0);
      dir_tab[15] = req_row(mco_pkg::REQ_IMG, 63, 0, 1, 1'b0, '0);
      dir_tab[16] = req_row(mco_pkg::REQ_IMG, 63, 1, 0, 1'b0, '0);
      dir_tab[17] = req_row(mco_pkg::REQ_NEXT, 0, 0, 0, 1'b0, '0);
      dir_tab[18] = req_row(mco_pkg::REQ_NEXT, 0, 0, 0, 1'b0, '0);
      dir_tab[19] = req_row(mco_pkg::REQ_NEXT, 0, 0, 0, 1'b0, '0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      tree_started = 1'b0;
      tree_done = 1'b0;
      cur_lvl = 0;

      // define every store entry a search below can read: empty graph on the
      // small vertex range, images of the small group, point 0 of the rest
      for (int unsigned r = 0; r < SMALL_N; r++)
         for (int unsigned c = 0; c < SMALL_N; c++)
            send_item(mco_pkg::REQ_ADJ, r, c, 0);
      for (int unsigned p = 0; p < SMALL_E; p++)
         for (int unsigned c = 0; c < SMALL_N; c++)
            send_item(mco_pkg::REQ_IMG, p, c, $urandom_range(0, 31));
      for (int unsigned p = SMALL_E; p < mco_pkg::MAX_ELEMENTS; p++)
         send_item(mco_pkg::REQ_IMG, p, 0, $urandom_range(0, 31));

      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_csr) write_reg(dir_tab[i].csr_reg, dir_tab[i].csr_val);
         else send_item(dir_tab[i].kind, dir_tab[i].row, dir_tab[i].col, dir_tab[i].val,
                        dir_tab[i].typed, dir_tab[i].res);
      end

      // random phases: small graphs, loads (some out of range) mixed with searches and restarts
      for (int unsigned ph = 0; ph < 8; ph++) begin
         n = $urandom_range(2, SMALL_N);
         e = $urandom_range(1, SMALL_E);
         if (ph == 5) begin
            // full group on a single vertex
            n = 1;
            e = 64;
         end
         write_reg(mco_pkg::CSR_NUM_POINTS, n);
         write_reg(mco_pkg::CSR_NUM_ELEMENTS, e);
         send_item(mco_pkg::REQ_RESTART, $urandom_range(0, 63), $urandom_range(0, 31),
                   $urandom_range(0, 31));
         for (int unsigned k = 0; k < 16; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
               send_item(mco_pkg::REQ_ADJ, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                         $urandom_range(0, 31));
            else if (pick < 50)
               send_item(mco_pkg::REQ_IMG, $urandom_range(0, e - 1), $urandom_range(0, n - 1),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(0, n - 1));
            else if (pick < 85)
               send_item(mco_pkg::REQ_NEXT, $urandom_range(0, 63), $urandom_range(0, 31),
                         $urandom_range(0, 31));
            else if (pick < 90)
               send_item(mco_pkg::REQ_RESTART, 0, 0, 0);
            else
               // noise: adjacency writes outside the vertex range
               send_item(mco_pkg::REQ_ADJ, $urandom_range(32, 63), $urandom_range(0, 31),
                         $urandom_range(0, 31));
         end
      end
      req_valid = 1'b0;

      wait (clique_expect_q.size() == 0);
      repeat (20) @(negedge clock);
      if (mismatches == 0 && clique_expect_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
sv/mco_pkg.sv
sv/mco_ram.sv
sv/mco_ctrl.sv
sv/mco_dp.sv
sv/maximal_clique_orbit_enumerator.sv
test/maximal_clique_orbit_enumerator_test.sv
